/* design/iso8601_utc_to_epoch_nanos_assert.svh */
// assertion macros shared by the checker
`ifndef ISO8601_UTC_TO_EPOCH_NANOS_ASSERT_SVH
`define ISO8601_UTC_TO_EPOCH_NANOS_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ISOEP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define ISOEP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/isoep_pkg.sv */
package isoep_pkg;

	typedef enum logic [4:0] {
		G_Y0, G_Y1, G_Y2, G_Y3, G_DASH1, G_MO0, G_MO1, G_DASH2, G_DY0, G_DY1,
		G_SEP_T, G_HR0, G_HR1, G_COLON1, G_MI0, G_MI1, G_COLON2, G_SE0, G_SE1,
		G_DOT_Z, G_FRAC0, G_FRAC, G_END
	} gstep_t;

	typedef enum logic [2:0] {
		C_PARSE, C_ERA, C_YOE, C_DOE, C_DAYS, C_SECS, C_MUL, C_SUM
	} cstate_t;

	typedef struct packed {
		logic parse;
		logic ld_era;
		logic ld_yoe;
		logic ld_doe;
		logic ld_days;
		logic ld_secs;
		logic ld_mul;
		logic ld_out;
	} cmd_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_MALFORMED = 2'd1;
	localparam logic [1:0] ST_RANGE     = 2'd2;

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_Z     = 8'h5A;

	localparam logic [29:0] NS_PER_SEC   = 30'd1000000000;
	// ceil(2^24 / 400), exact floor for years below 10000
	localparam logic [15:0] ERA_RECIP    = 16'd41944;
	localparam logic [3:0]  FRAC_DIGITS  = 4'd9;

	localparam logic signed [40:0] SECS_MAX = 41'sd9223372036;
	localparam logic signed [40:0] SECS_MIN = -41'sd9223372037;
	localparam logic [29:0] FRAC_MAX = 30'd854775807;
	localparam logic [29:0] FRAC_MIN = 30'd145224192;

	// days before the month, march-based year
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// scale that pads a fraction of cnt digits to nanoseconds
	function automatic logic [29:0] pad_scale(input logic [3:0] cnt);
		logic [29:0] r;
		case (cnt)
			4'd0:    r = 30'd1000000000;
			4'd1:    r = 30'd100000000;
			4'd2:    r = 30'd10000000;
			4'd3:    r = 30'd1000000;
			4'd4:    r = 30'd100000;
			4'd5:    r = 30'd10000;
			4'd6:    r = 30'd1000;
			4'd7:    r = 30'd100;
			4'd8:    r = 30'd10;
			default: r = 30'd1;
		endcase
		return r;
	endfunction

endpackage

/* design/iso8601_utc_to_epoch_nanos.sv */
// channel  valid      stall      payload
// input    in_valid   in_stall   character, last_char
// output   out_valid  out_stall  status, epoch_nanos
//
// one character is taken per cycle while parsing
// after the last character the input stalls while the conversion sequencer
// walks era, year-of-era, day-of-era, days, seconds, multiply and sum; the
// stall lasts longer if the output register is still held by a stalled
// earlier request
// reset clears the parser, the sequencer and the output valid
module iso8601_utc_to_epoch_nanos import isoep_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         character,
	input  logic               last_char,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [63:0] epoch_nanos
);

	cmd_t cmd;

	isoep_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.last_char (last_char),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	isoep_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.character   (character),
		.status      (status),
		.epoch_nanos (epoch_nanos)
	);

endmodule

/* design/isoep_ctrl.sv */
module isoep_ctrl import isoep_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic last_char,
	input  logic out_stall,
	output logic in_stall,
	output logic out_valid,
	output cmd_t cmd
);

	cstate_t state_q, state_d;
	logic    out_valid_q;
	logic    accept;
	logic    out_free;

	assign accept   = in_valid && (state_q == C_PARSE);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			C_PARSE: if (accept && last_char) state_d = C_ERA;
			C_ERA:   state_d = C_YOE;
			C_YOE:   state_d = C_DOE;
			C_DOE:   state_d = C_DAYS;
			C_DAYS:  state_d = C_SECS;
			C_SECS:  state_d = C_MUL;
			C_MUL:   state_d = C_SUM;
			C_SUM:   if (out_free) state_d = C_PARSE;
			default: state_d = C_PARSE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			C_PARSE: begin
				in_stall  = 1'b0;
				cmd.parse = accept;
			end
			C_ERA:   cmd.ld_era  = 1'b1;
			C_YOE:   cmd.ld_yoe  = 1'b1;
			C_DOE:   cmd.ld_doe  = 1'b1;
			C_DAYS:  cmd.ld_days = 1'b1;
			C_SECS:  cmd.ld_secs = 1'b1;
			C_MUL:   cmd.ld_mul  = 1'b1;
			C_SUM:   cmd.ld_out  = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= C_PARSE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

/* design/isoep_dp.sv */
module isoep_dp import isoep_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic [7:0]         character,
	output logic [1:0]         status,
	output logic signed [63:0] epoch_nanos
);

	// parser state
	gstep_t      step_q, step_d;
	logic        failed_q;
	logic [13:0] year_q, year_d;
	logic [6:0]  month_q, month_d;
	logic [6:0]  day_q, day_d;
	logic [6:0]  hour_q, hour_d;
	logic [6:0]  minute_q, minute_d;
	logic [6:0]  second_q, second_d;
	logic [29:0] frac_q, frac_d;
	logic [3:0]  cnt_q, cnt_d;
	logic        bad;
	logic        is_dig;
	logic [3:0]  dig;
	logic [4:0]  step_inc;

	// conversion registers
	logic               ok_q;
	logic signed [14:0] yy_q;
	logic signed [5:0]  era_q;
	logic [8:0]         doy_q;
	logic [16:0]        hms_q;
	logic [29:0]        fpad_q;
	logic [8:0]         yoe_q;
	logic [17:0]        doe_q;
	logic signed [23:0] days_q;
	logic signed [40:0] secs_q;
	logic               fits_q;
	logic [48:0]        plo_q;
	logic signed [47:0] phi_q;
	logic [1:0]         status_q;
	logic signed [63:0] epoch_q;

	logic               fmt_ok;
	logic               early;
	logic signed [14:0] yy_w;
	logic [29:0]        era_prod;
	logic signed [5:0]  era_w;
	logic [3:0]         mp;
	logic signed [15:0] yoe_w;
	logic [1:0]         cent;
	logic signed [23:0] days_w;
	logic signed [40:0] secs_w;
	logic               fits_w;
	logic [48:0]        plo_w;
	logic signed [47:0] phi_w;
	logic [63:0]        ns_w;

	assign is_dig   = (character >= CH_0) && (character <= CH_9);
	assign dig      = is_dig ? character[3:0] : 4'd0;
	assign step_inc = step_q + 5'd1;

	always_comb begin
		step_d   = gstep_t'(step_inc);
		bad      = 1'b0;
		year_d   = year_q;
		month_d  = month_q;
		day_d    = day_q;
		hour_d   = hour_q;
		minute_d = minute_q;
		second_d = second_q;
		frac_d   = frac_q;
		cnt_d    = cnt_q;
		unique case (step_q) inside
			G_Y0, G_Y1, G_Y2, G_Y3: begin
				bad    = !is_dig;
				year_d = 14'(year_q * 14'd10 + 14'(dig));
			end
			G_DASH1, G_DASH2: bad = (character != CH_DASH);
			G_MO0, G_MO1: begin
				bad     = !is_dig;
				month_d = 7'(month_q * 7'd10 + 7'(dig));
			end
			G_DY0, G_DY1: begin
				bad   = !is_dig;
				day_d = 7'(day_q * 7'd10 + 7'(dig));
			end
			G_SEP_T: bad = (character != CH_T);
			G_HR0, G_HR1: begin
				bad    = !is_dig;
				hour_d = 7'(hour_q * 7'd10 + 7'(dig));
			end
			G_COLON1, G_COLON2: bad = (character != CH_COLON);
			G_MI0, G_MI1: begin
				bad      = !is_dig;
				minute_d = 7'(minute_q * 7'd10 + 7'(dig));
			end
			G_SE0, G_SE1: begin
				bad      = !is_dig;
				second_d = 7'(second_q * 7'd10 + 7'(dig));
			end
			G_DOT_Z: begin
				if (character == CH_DOT) begin
					step_d = G_FRAC0;
				end else if (character == CH_Z) begin
					step_d = G_END;
				end else begin
					bad = 1'b1;
				end
			end
			G_FRAC0, G_FRAC: begin
				if (is_dig) begin
					step_d = G_FRAC;
					if (cnt_q < FRAC_DIGITS) begin
						frac_d = 30'(frac_q * 30'd10 + 30'(dig));
						cnt_d  = cnt_q + 4'd1;
					end
				end else if ((step_q == G_FRAC) && (character == CH_Z)) begin
					step_d = G_END;
				end else begin
					bad = 1'b1;
				end
			end
			default: bad = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= G_Y0;
			failed_q <= 1'b0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			frac_q   <= '0;
			cnt_q    <= '0;
		end else if (cmd.ld_out) begin
			step_q   <= G_Y0;
			failed_q <= 1'b0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			frac_q   <= '0;
			cnt_q    <= '0;
		end else if (cmd.parse && !failed_q) begin
			if (bad) begin
				failed_q <= 1'b1;
			end else begin
				step_q   <= step_d;
				year_q   <= year_d;
				month_q  <= month_d;
				day_q    <= day_d;
				hour_q   <= hour_d;
				minute_q <= minute_d;
				second_q <= second_d;
				frac_q   <= frac_d;
				cnt_q    <= cnt_d;
			end
		end
	end

	assign fmt_ok = !failed_q && ((step_q == G_SEP_T) || (step_q == G_END))
		&& (month_q >= 7'd1) && (month_q <= 7'd12)
		&& (day_q >= 7'd1) && (day_q <= 7'd31)
		&& (hour_q <= 7'd23) && (minute_q <= 7'd59) && (second_q <= 7'd60);

	// era and day of year
	assign early    = (month_q <= 7'd2);
	assign yy_w     = $signed({1'b0, year_q}) - (early ? 15'sd1 : 15'sd0);
	assign era_prod = 30'(yy_w[13:0]) * 30'(ERA_RECIP);
	assign era_w    = yy_w[14] ? -6'sd1 : $signed(era_prod[29:24]);
	assign mp       = (month_q > 7'd2) ? 4'(month_q - 7'd3) : 4'(month_q + 7'd9);

	assign yoe_w = 16'(yy_q) - 16'(era_q) * 16'sd400;
	assign cent  = (yoe_q >= 9'd300) ? 2'd3 :
		(yoe_q >= 9'd200) ? 2'd2 :
		(yoe_q >= 9'd100) ? 2'd1 : 2'd0;

	assign days_w = 24'(era_q) * 24'sd146097 + $signed({6'd0, doe_q}) - 24'sd719468;
	assign secs_w = 41'(days_q) * 41'sd86400 + $signed({24'd0, hms_q});

	assign fits_w = ((secs_q < SECS_MAX) || ((secs_q == SECS_MAX) && (fpad_q <= FRAC_MAX)))
		&& ((secs_q > SECS_MIN) || ((secs_q == SECS_MIN) && (fpad_q >= FRAC_MIN)));

	// seconds split at bit 18 so each product stays narrow
	assign plo_w = 49'(secs_q[17:0]) * 49'(NS_PER_SEC) + 49'(fpad_q);
	assign phi_w = 48'($signed(secs_q[34:18])) * $signed({18'd0, NS_PER_SEC});
	assign ns_w  = 64'({phi_q, 18'd0}) + 64'(plo_q);

	always_ff @(posedge clk) begin
		if (cmd.ld_era) begin
			ok_q   <= fmt_ok;
			yy_q   <= yy_w;
			era_q  <= era_w;
			doy_q  <= 9'(month_start(mp)) + 9'(day_q) - 9'd1;
			hms_q  <= 17'(hour_q) * 17'd3600 + 17'(minute_q) * 17'd60 + 17'(second_q);
			fpad_q <= 30'(frac_q * pad_scale(cnt_q));
		end
		if (cmd.ld_yoe) begin
			yoe_q <= yoe_w[8:0];
		end
		if (cmd.ld_doe) begin
			doe_q <= 18'(yoe_q) * 18'd365 + 18'(yoe_q[8:2]) - 18'(cent) + 18'(doy_q);
		end
		if (cmd.ld_days) begin
			days_q <= days_w;
		end
		if (cmd.ld_secs) begin
			secs_q <= secs_w;
		end
		if (cmd.ld_mul) begin
			fits_q <= fits_w;
			plo_q  <= plo_w;
			phi_q  <= phi_w;
		end
		if (cmd.ld_out) begin
			if (!ok_q) begin
				status_q <= ST_MALFORMED;
				epoch_q  <= '0;
			end else if (!fits_q) begin
				status_q <= ST_RANGE;
				epoch_q  <= '0;
			end else begin
				status_q <= ST_OK;
				epoch_q  <= $signed(ns_w);
			end
		end
	end

	assign status      = status_q;
	assign epoch_nanos = epoch_q;

endmodule

/* design/isoep_chk.sv */
`include "iso8601_utc_to_epoch_nanos_assert.svh"

module isoep_chk import isoep_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               last_char,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         status,
	input logic signed [63:0] epoch_nanos
);

	`ISOEP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(epoch_nanos), "stalled result changed")
	`ISOEP_ASSERT_IMP(a_status_code, out_valid, status == ST_OK || status == ST_MALFORMED || status == ST_RANGE, "bad status code")
	`ISOEP_ASSERT_IMP(a_zero_on_fail, out_valid && (status != ST_OK), epoch_nanos == '0, "nonzero value on failure")
	`ISOEP_ASSERT_NXT(a_busy_after_last, in_valid && !in_stall && last_char, in_stall, "input taken during conversion")
	`ISOEP_ASSERT_NXT(a_no_early_result, in_valid && !in_stall && !last_char && !out_valid, !out_valid, "result before last character")

endmodule

bind iso8601_utc_to_epoch_nanos isoep_chk u_chk (.*);

/* tb/tb_iso8601_utc_to_epoch_nanos.sv */
module tb_iso8601_utc_to_epoch_nanos;
	import isoep_pkg::*;

	localparam longint SECS_TOP = 64'sd9223372036;
	localparam longint SECS_BOTTOM = -64'sd9223372037;
	localparam longint FRAC_TOP = 64'sd854775807;
	localparam longint FRAC_BOTTOM = 64'sd145224192;
	localparam longint NANOS_PER_SEC = 64'sd1000000000;

	typedef struct {
		logic [1:0] status;
		logic signed [63:0] nanos;
	} conversion_t;

	class epoch_board;
		gstep_t step;
		bit broken;
		logic [13:0] year;
		logic [6:0] month, day, hour, minute, second;
		logic [29:0] fraction;
		logic [3:0] frac_digits;
		conversion_t awaited_conversions[$];
		int errors;

		function new();
			clear();
			errors = 0;
		endfunction

		function void clear();
			step = G_Y0;
			broken = 1'b0;
			year = '0;
			month = '0;
			day = '0;
			hour = '0;
			minute = '0;
			second = '0;
			fraction = '0;
			frac_digits = '0;
		endfunction

		task report(input string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		// parse one accepted character, queue a conversion on the last one
		task note_request(input logic [7:0] ch, input logic lst);
			logic is_dig;
			logic [3:0] dig;
			conversion_t want;
			longint y, m, era, yoe, doy, doe, secs, frac;
			bit fits;
			is_dig = ch >= CH_0 && ch <= CH_9;
			dig = is_dig ? 4'(ch - CH_0) : 4'd0;
			if (!broken) begin
				case (step)
					G_Y0, G_Y1, G_Y2, G_Y3: begin
						if (is_dig) year = 14'(year * 10 + dig);
						else broken = 1'b1;
					end
					G_DASH1, G_DASH2: begin
						if (ch != CH_DASH) broken = 1'b1;
					end
					G_MO0, G_MO1: begin
						if (is_dig) month = 7'(month * 10 + dig);
						else broken = 1'b1;
					end
					G_DY0, G_DY1: begin
						if (is_dig) day = 7'(day * 10 + dig);
						else broken = 1'b1;
					end
					G_SEP_T: begin
						if (ch != CH_T) broken = 1'b1;
					end
					G_HR0, G_HR1: begin
						if (is_dig) hour = 7'(hour * 10 + dig);
						else broken = 1'b1;
					end
					G_COLON1, G_COLON2: begin
						if (ch != CH_COLON) broken = 1'b1;
					end
					G_MI0, G_MI1: begin
						if (is_dig) minute = 7'(minute * 10 + dig);
						else broken = 1'b1;
					end
					G_SE0, G_SE1: begin
						if (is_dig) second = 7'(second * 10 + dig);
						else broken = 1'b1;
					end
					G_DOT_Z: begin
						if (ch == CH_DOT) step = G_FRAC0;
						else if (ch == CH_Z) step = G_END;
						else broken = 1'b1;
					end
					G_FRAC0, G_FRAC: begin
						if (is_dig) begin
							if (frac_digits < 9) begin
								fraction = 30'(fraction * 10 + dig);
								frac_digits++;
							end
							step = G_FRAC;
						end else if (step == G_FRAC && ch == CH_Z) begin
							step = G_END;
						end else begin
							broken = 1'b1;
						end
					end
					default: broken = 1'b1;
				endcase
				if (!broken && step <= G_SE1) step = gstep_t'(step + 5'd1);
			end
			if (lst) begin
				want.status = ST_MALFORMED;
				want.nanos = '0;
				if (!broken && (step == G_SEP_T || step == G_END) &&
						month >= 1 && month <= 12 && day >= 1 && day <= 31 &&
						hour <= 23 && minute <= 59 && second <= 60) begin
					y = year;
					m = month;
					if (m <= 2) y = y - 1;
					era = (y >= 0 ? y : y - 399) / 400;
					yoe = y - era * 400;
					doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + longint'(day) - 1;
					doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
					secs = (era * 146097 + doe - 719468) * 86400 +
						longint'(hour) * 3600 + longint'(minute) * 60 + longint'(second);
					frac = fraction;
					for (int k = frac_digits; k < 9; k++) frac = frac * 10;
					if (secs > SECS_TOP) fits = 1'b0;
					else if (secs == SECS_TOP) fits = frac <= FRAC_TOP;
					else if (secs < SECS_BOTTOM) fits = 1'b0;
					else if (secs == SECS_BOTTOM) fits = frac >= FRAC_BOTTOM;
					else fits = 1'b1;
					if (fits) begin
						want.status = ST_OK;
						want.nanos = secs * NANOS_PER_SEC + frac;
					end else begin
						want.status = ST_RANGE;
					end
				end
				awaited_conversions.push_back(want);
				clear();
			end
		endtask

		task check_result(input logic [1:0] st, input logic signed [63:0] ns);
			conversion_t want;
			if (awaited_conversions.size() == 0) begin
				report($sformatf("result with nothing pending: status %0d nanos %0d", st, ns));
				return;
			end
			want = awaited_conversions.pop_front();
			if (st !== want.status)
				report($sformatf("status got %0d expected %0d", st, want.status));
			if (ns !== want.nanos)
				report($sformatf("epoch_nanos got %0d expected %0d", ns, want.nanos));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [7:0] character;
	logic last_char;
	logic out_valid;
	logic out_stall;
	logic [1:0] status;
	logic signed [63:0] epoch_nanos;

	epoch_board board = new();
	logic [7:0] stamp_text[$];
	bit calm;
	int random_chars;
	int pick;

	iso8601_utc_to_epoch_nanos dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.character(character),
		.last_char(last_char),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.epoch_nanos(epoch_nanos)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 400000);
		$display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_result(status, epoch_nanos);
		out_stall <= !calm && ($urandom_range(99) < 18);
	end

	task automatic send_text();
		for (int i = 0; i < stamp_text.size(); i++) begin
			if (!calm) begin
				while ($urandom_range(99) < 18) begin
					in_valid <= 1'b0;
					@(posedge clk);
				end
			end
			in_valid <= 1'b1;
			character <= stamp_text[i];
			last_char <= (i == stamp_text.size() - 1);
			@(posedge clk);
			while (in_stall) @(posedge clk);
			board.note_request(stamp_text[i], i == stamp_text.size() - 1);
		end
	endtask

	task automatic send_str(input string s);
		stamp_text.delete();
		for (int i = 0; i < s.len(); i++) stamp_text.push_back(s[i]);
		send_text();
	endtask

	function automatic void put_digits(input int value, input int count);
		for (int i = count - 1; i >= 0; i--)
			stamp_text.push_back(8'(CH_0 + (value / (10 ** i)) % 10));
	endfunction

	// well-formed shape, fields mostly in range
	function automatic void build_stamp();
		stamp_text.delete();
		put_digits($urandom_range(1) ? $urandom_range(1678, 2261) : $urandom_range(9999), 4);
		stamp_text.push_back(CH_DASH);
		put_digits($urandom_range(99) < 85 ? $urandom_range(1, 12) : $urandom_range(99), 2);
		stamp_text.push_back(CH_DASH);
		put_digits($urandom_range(99) < 85 ? $urandom_range(1, 31) : $urandom_range(99), 2);
		if ($urandom_range(4) == 0) return;
		stamp_text.push_back(CH_T);
		put_digits($urandom_range(99) < 85 ? $urandom_range(23) : $urandom_range(99), 2);
		stamp_text.push_back(CH_COLON);
		put_digits($urandom_range(99) < 85 ? $urandom_range(59) : $urandom_range(99), 2);
		stamp_text.push_back(CH_COLON);
		put_digits($urandom_range(99) < 85 ? $urandom_range(60) : $urandom_range(99), 2);
		if ($urandom_range(2) != 0) begin
			stamp_text.push_back(CH_DOT);
			repeat ($urandom_range(1, 14)) stamp_text.push_back(8'(CH_0 + $urandom_range(9)));
		end
		stamp_text.push_back(CH_Z);
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		character = '0;
		last_char = 1'b0;
		out_stall = 1'b0;
		calm = 1'b0;
		random_chars = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_str("1970-01-01");
		send_str("1970-01-01T00:00:00Z");
		send_str("2262-04-11T23:47:16.854775807Z");
		send_str("2262-04-11T23:47:16.854775808Z");
		send_str("1677-09-21T00:12:43.145224192Z");
		send_str("1677-09-21T00:12:43.145224191Z");
		send_str("0000-01-01");
		send_str("9999-12-31T23:59:60.999999999999Z");
		send_str("2000-02-31");
		send_str("2024-13-01");
		send_str("2024-00-10");
		send_str("2024-01-32");
		send_str("2024-01-01T24:00:00Z");
		send_str("2024-01-01T23:60:00Z");
		send_str("2024-01-01T23:59:61Z");
		send_str("2016-12-31T23:59:60Z");
		send_str("2024-01-01T12:00:00.Z");
		send_str("2024-01-01T12:00:00.5Z");
		send_str("2024-01-01T12:00:00ZX");
		send_str("2024-01-0");
		send_str("2024/01-01T00:00:00Z");
		send_str("1969-12-31T23:59:59.123456789012345Z");
		stamp_text = {8'hFF};
		send_text();
		stamp_text = {8'h00, 8'h80, 8'h7F};
		send_text();

		// let every pending conversion drain before the random part
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.awaited_conversions.size() != 0) @(posedge clk);

		for (int n = 0; random_chars < 1200; n++) begin
			calm <= n >= 30 && n < 45;
			pick = $urandom_range(99);
			if (pick < 85) build_stamp();
			if (pick >= 70 && pick < 85) begin
				case ($urandom_range(2))
					0: stamp_text[$urandom_range(stamp_text.size() - 1)] = 8'($urandom_range(255));
					1: stamp_text = stamp_text[0:$urandom_range(stamp_text.size() - 2)];
					default: repeat ($urandom_range(1, 3)) stamp_text.push_back(8'($urandom_range(255)));
				endcase
			end else if (pick >= 85) begin
				stamp_text.delete();
				repeat ($urandom_range(1, 30)) stamp_text.push_back(8'($urandom_range(255)));
			end
			send_text();
			random_chars += stamp_text.size();
		end

		in_valid <= 1'b0;
		calm <= 1'b0;
		@(posedge clk);
		while (board.awaited_conversions.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
